// File: design/vgf_pkg.sv
package vgf_pkg;

  // fixed field widths
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned PITCH_W = 17;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NUM_CHAN = 3;

  // default frame limits
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  // register reset values
  localparam logic [COLOR_W-1:0] RST_TOP_COLOR    = 24'h000000;
  localparam logic [COLOR_W-1:0] RST_BOTTOM_COLOR = 24'hFFFFFF;
  localparam logic [SIZE_W-1:0]  RST_FB_WIDTH     = 13'd640;
  localparam logic [SIZE_W-1:0]  RST_FB_HEIGHT    = 13'd480;
  localparam logic [PITCH_W-1:0] RST_ROW_PITCH    = 17'd2560;
  localparam logic [ADDR_W-1:0]  RST_FRAME_BASE   = 32'h0000_0000;

  // register indexes
  typedef enum logic [2:0] {
    REG_TOP_COLOR    = 3'd0,
    REG_BOTTOM_COLOR = 3'd1,
    REG_FB_WIDTH     = 3'd2,
    REG_FB_HEIGHT    = 3'd3,
    REG_ROW_PITCH    = 3'd4,
    REG_FRAME_BASE   = 3'd5
  } vgf_reg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic mul_load;
    logic color_load;
    logic out_load;
  } vgf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic col_zero;
    logic div_done;
    logic out_free;
  } vgf_stat_t;

endpackage

// File: design/vgf_div.sv
module vgf_div #(
  parameter int unsigned IDX_W = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vgf_pkg::COLOR_W-1:0]   top_color,
  input  logic [vgf_pkg::COLOR_W-1:0]   bottom_color,
  input  logic [IDX_W-1:0]              num,
  input  logic [IDX_W-1:0]              den,
  output logic [vgf_pkg::COLOR_W-1:0]   color,
  output logic                          done
);

  localparam int unsigned CW    = vgf_pkg::CHAN_W;
  localparam int unsigned DVD_W = CW + IDX_W;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] den_q;
  logic             den_zero;

  assign done = (cnt == '0);

  // shared iteration count and divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DVD_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q    <= den;
      den_zero <= (den == '0);
    end
  end

  // one restoring divider lane per channel, one quotient bit per cycle
  for (genvar c = 0; c < vgf_pkg::NUM_CHAN; c++) begin : g_lane
    logic [CW-1:0]    t_in, b_in, diff;
    logic             neg_in;
    logic [DVD_W-1:0] prod;
    logic [CW-1:0]    t_q;
    logic             neg_q;
    logic [IDX_W:0]   rem;
    logic [DVD_W-1:0] quo;
    logic [IDX_W:0]   rem_sh;
    logic             ge;
    logic [CW-1:0]    q8;

    assign t_in   = top_color[c*CW +: CW];
    assign b_in   = bottom_color[c*CW +: CW];
    assign neg_in = (b_in < t_in);
    assign diff   = neg_in ? (t_in - b_in) : (b_in - t_in);
    assign prod   = {{IDX_W{1'b0}}, diff} * {{CW{1'b0}}, num};

    assign rem_sh = {rem[IDX_W-1:0], quo[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_q});

    always_ff @(posedge clk) begin
      if (start) begin
        t_q   <= t_in;
        neg_q <= neg_in;
        rem   <= '0;
        quo   <= prod;
      end else if (cnt != '0) begin
        rem <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        quo <= {quo[DVD_W-2:0], ge};
      end
    end

    // quotient never exceeds the channel difference
    assign q8 = quo[CW-1:0];
    assign color[c*CW +: CW] = den_zero ? t_q : (neg_q ? (t_q - q8) : (t_q + q8));
  end

endmodule

// File: design/vgf_ctrl.sv
module vgf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vgf_pkg::vgf_stat_t stat,
  output vgf_pkg::vgf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.mul_load = 1'b1;
        if (!stat.active) begin
          state_next = S_IDLE;
        end else if (stat.col_zero) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.color_load = 1'b1;
          state_next     = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/vgf_datapath.sv
module vgf_datapath #(
  parameter int unsigned MAX_WIDTH  = vgf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = vgf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vgf_pkg::vgf_cmd_t             cmd,
  output vgf_pkg::vgf_stat_t            stat,
  input  logic                          restart,
  input  logic [vgf_pkg::COLOR_W-1:0]   top_color,
  input  logic [vgf_pkg::COLOR_W-1:0]   bottom_color,
  input  logic [vgf_pkg::SIZE_W-1:0]    fb_width,
  input  logic [vgf_pkg::SIZE_W-1:0]    fb_height,
  input  logic [vgf_pkg::PITCH_W-1:0]   row_pitch,
  input  logic [vgf_pkg::ADDR_W-1:0]    frame_base,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vgf_pkg::ADDR_W-1:0]    write_address,
  output logic [vgf_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          frame_last
);

  localparam int unsigned CIDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RIDX_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned PROD_W = RIDX_W + vgf_pkg::PITCH_W;
  localparam int unsigned AW     = vgf_pkg::ADDR_W;

  logic [CIDX_W-1:0] column_index;
  logic [RIDX_W-1:0] row_index;
  logic              fill_active;
  logic [vgf_pkg::COLOR_W-1:0] row_color;
  logic [PROD_W-1:0] row_offset;

  logic [31:0]       w_lim, h_lim;
  logic [CIDX_W-1:0] w_m1;
  logic [RIDX_W-1:0] h_m1;
  logic [RIDX_W-1:0] num;
  logic              row_end, frame_end;
  logic [vgf_pkg::COLOR_W-1:0] div_color;
  logic              div_done;

  // last column and row after clamping the size registers
  always_comb begin
    if (fb_width == '0) begin
      w_lim = 32'd0;
    end else if (32'(fb_width) > 32'(MAX_WIDTH)) begin
      w_lim = 32'(MAX_WIDTH) - 32'd1;
    end else begin
      w_lim = 32'(fb_width) - 32'd1;
    end
    if (fb_height == '0) begin
      h_lim = 32'd0;
    end else if (32'(fb_height) > 32'(MAX_HEIGHT)) begin
      h_lim = 32'(MAX_HEIGHT) - 32'd1;
    end else begin
      h_lim = 32'(fb_height) - 32'd1;
    end
  end

  assign w_m1      = w_lim[CIDX_W-1:0];
  assign h_m1      = h_lim[RIDX_W-1:0];
  assign num       = (row_index > h_m1) ? h_m1 : row_index;
  assign row_end   = (column_index >= w_m1);
  assign frame_end = row_end && (row_index >= h_m1);

  vgf_div #(
    .IDX_W (RIDX_W)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (cmd.div_start),
    .top_color    (top_color),
    .bottom_color (bottom_color),
    .num          (num),
    .den          (h_m1),
    .color        (div_color),
    .done         (div_done)
  );

  // scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      fill_active  <= 1'b1;
    end else if (cmd.accept && restart) begin
      column_index <= '0;
      row_index    <= '0;
      fill_active  <= 1'b1;
    end else if (cmd.out_load) begin
      if (frame_end) begin
        column_index <= '0;
        row_index    <= '0;
        fill_active  <= 1'b0;
      end else if (row_end) begin
        column_index <= '0;
        row_index    <= row_index + 1'b1;
      end else begin
        column_index <= column_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_color <= '0;
    end else if (cmd.color_load) begin
      row_color <= div_color;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      row_offset <= {{vgf_pkg::PITCH_W{1'b0}}, row_index} *
                    {{RIDX_W{1'b0}}, row_pitch};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      write_address <= frame_base + AW'(row_offset) + AW'({column_index, 2'b00});
      pixel_color   <= row_color;
      frame_last    <= frame_end;
    end
  end

  assign stat.active   = fill_active;
  assign stat.col_zero = (column_index == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

// File: design/vertical_gradient_fill_core.sv
// vertical gradient fill engine: every beat accepted on the slave stream makes at most one
// pixel write on the master stream, scanning the frame top to bottom and left to right at
// address frame_base + row * row_pitch + column * 4 (modulo 2^32); each row's color is the
// per-channel blend of top_color and bottom_color by row / (height - 1), truncated toward
// zero, and tlast marks the final pixel; after that beat the engine is idle and a beat
// with restart low yields nothing until a beat with restart high starts a new frame (a
// frame also starts after reset); a pixel passes the idle, check and load states from
// input beat to output register, and a pixel in column zero also waits in the divide state
// while the three bit-serial channel dividers produce the row color, one quotient bit per
// cycle; the output register lets the next input beat in while a pixel awaits m_axis_tready
module vertical_gradient_fill_core #(
  parameter int unsigned MAX_WIDTH  = vgf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = vgf_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] write_address, [55:32] pixel_color
  output logic        m_axis_tlast    // frame_last
);

  logic [vgf_pkg::COLOR_W-1:0] top_color;
  logic [vgf_pkg::COLOR_W-1:0] bottom_color;
  logic [vgf_pkg::SIZE_W-1:0]  fb_width;
  logic [vgf_pkg::SIZE_W-1:0]  fb_height;
  logic [vgf_pkg::PITCH_W-1:0] row_pitch;
  logic [vgf_pkg::ADDR_W-1:0]  frame_base;

  vgf_pkg::vgf_cmd_t  cmd;
  vgf_pkg::vgf_stat_t stat;

  logic [vgf_pkg::ADDR_W-1:0]  write_address;
  logic [vgf_pkg::COLOR_W-1:0] pixel_color;

  // configuration registers, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      top_color    <= vgf_pkg::RST_TOP_COLOR;
      bottom_color <= vgf_pkg::RST_BOTTOM_COLOR;
      fb_width     <= vgf_pkg::RST_FB_WIDTH;
      fb_height    <= vgf_pkg::RST_FB_HEIGHT;
      row_pitch    <= vgf_pkg::RST_ROW_PITCH;
      frame_base   <= vgf_pkg::RST_FRAME_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        vgf_pkg::REG_TOP_COLOR:    top_color    <= cfg_data[vgf_pkg::COLOR_W-1:0];
        vgf_pkg::REG_BOTTOM_COLOR: bottom_color <= cfg_data[vgf_pkg::COLOR_W-1:0];
        vgf_pkg::REG_FB_WIDTH:     fb_width     <= cfg_data[vgf_pkg::SIZE_W-1:0];
        vgf_pkg::REG_FB_HEIGHT:    fb_height    <= cfg_data[vgf_pkg::SIZE_W-1:0];
        vgf_pkg::REG_ROW_PITCH:    row_pitch    <= cfg_data[vgf_pkg::PITCH_W-1:0];
        vgf_pkg::REG_FRAME_BASE:   frame_base   <= cfg_data[vgf_pkg::ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: accept, multiply and branch, optional row color divide, load output
  vgf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // scan counters, address math, row color divider and output register
  vgf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .restart       (s_axis_tdata[0]),
    .top_color     (top_color),
    .bottom_color  (bottom_color),
    .fb_width      (fb_width),
    .fb_height     (fb_height),
    .row_pitch     (row_pitch),
    .frame_base    (frame_base),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .write_address (write_address),
    .pixel_color   (pixel_color),
    .frame_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {pixel_color, write_address};

endmodule
